>>> src/whs_pkg.sv
package whs_pkg;

    localparam int SAMPLE_W = 18;
    localparam int BINS_W   = 7;
    localparam int WIN_W    = 15;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 15;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int PROD_W   = 25;

    localparam logic [18:0] ONE_FIX  = 19'd65536;
    localparam logic [17:0] SPAN_FIX = 18'd131072;

    localparam logic [CNT_W-1:0]  CNT_MAX      = 15'h7FFF;
    localparam logic [BINS_W-1:0] RESET_BINS   = 7'd64;
    localparam logic [WIN_W-1:0]  RESET_WINDOW = 15'd1024;
    localparam int                DEFAULT_BINS   = 100;
    localparam int                DEFAULT_WINDOW = 1024;

    localparam logic CFG_BIN_COUNT     = 1'b0;
    localparam logic CFG_WINDOW_LENGTH = 1'b1;

    typedef struct packed {
        logic load;
        logic map;
        logic rd;
        logic wr;
        logic emit_rd;
        logic emit_ld;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

>>> src/whs_ram.sv
module whs_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/whs_ctrl.sv
module whs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  whs_pkg::t_status i_status,
    output whs_pkg::t_cmd   o_cmd
);

    import whs_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MAP     = 3'd1;
    localparam logic [2:0] S_READ    = 3'd2;
    localparam logic [2:0] S_WRITE   = 3'd3;
    localparam logic [2:0] S_EMIT_RD = 3'd4;
    localparam logic [2:0] S_EMIT_LD = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = i_status.fill_done ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    n_state       = i_status.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> src/whs_dpath.sv
module whs_dpath #(
    parameter int MAX_BINS   = 64,
    parameter int MAX_WINDOW = 30000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  whs_pkg::t_cmd                       i_cmd,
    output whs_pkg::t_status                    o_status,
    input  logic [whs_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic                                i_eos,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_index,
    input  logic [whs_pkg::WIN_W-1:0]           i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [whs_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic                                o_out_last
);

    import whs_pkg::*;

    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [BINS_W-1:0] BINS_LIM = BINS_W'(MAX_BINS);
    localparam logic [WIN_W-1:0]  WIN_LIM  = WIN_W'(MAX_WINDOW);
    localparam logic [BINS_W-1:0] DEF_BINS =
        BINS_W'((DEFAULT_BINS > MAX_BINS) ? MAX_BINS : DEFAULT_BINS);
    localparam logic [WIN_W-1:0]  DEF_WIN  =
        WIN_W'((DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW);

    logic [BINS_W-1:0]   r_bin_count;
    logic [WIN_W-1:0]    r_window_length;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_eos;
    logic [WIN_W-1:0]    r_fill;
    logic [IDX_W-1:0]    r_bin;
    logic                r_hit;
    logic [IDX_W-1:0]    r_j;
    logic [MAX_BINS-1:0] r_valid;
    logic                r_rd_valid;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [CNT_W-1:0]    r_out_total;
    logic                r_out_last;

    logic                bad_cfg;
    logic [BINS_W-1:0]   m_eff;
    logic [WIN_W-1:0]    n_eff;
    logic [18:0]         u_val;
    logic                hit;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_m1;
    logic [CNT_W-1:0]    rd_data;
    logic [CNT_W-1:0]    cur_cnt;
    logic                do_write;
    logic [ADDR_W-1:0]   raddr;
    logic                emit_last;

    assign bad_cfg = (r_window_length == '0) || (r_window_length > WIN_LIM) ||
                     (r_bin_count == '0);
    assign m_eff = bad_cfg ? DEF_BINS :
                   ((r_bin_count > BINS_LIM) ? BINS_LIM : r_bin_count);
    assign n_eff = bad_cfg ? DEF_WIN : r_window_length;

    // bin = (u * m - 1) / 2^17 for 0 < u <= 2^17
    assign u_val   = {r_sample[SAMPLE_W-1], r_sample} + ONE_FIX;
    assign hit     = !u_val[18] && (u_val != '0) && (u_val[17:0] <= SPAN_FIX);
    assign prod    = {7'b0, u_val[17:0]} * {18'b0, m_eff};
    assign prod_m1 = prod - PROD_W'(1);

    assign raddr    = i_cmd.rd ? r_bin[ADDR_W-1:0] : r_j[ADDR_W-1:0];
    assign cur_cnt  = r_rd_valid ? rd_data : '0;
    assign do_write = i_cmd.wr && r_hit && (cur_cnt != CNT_MAX);
    assign emit_last = ({1'b0, r_j} == (m_eff - BINS_W'(1)));

    assign o_status.fill_done = (r_fill >= n_eff) || r_eos;
    assign o_status.emit_last = emit_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    whs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BINS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_bin[ADDR_W-1:0]),
        .i_wdata (cur_cnt + CNT_W'(1)),
        .i_re    (i_cmd.rd || i_cmd.emit_rd),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count     <= RESET_BINS;
            r_window_length <= RESET_WINDOW;
            r_fill          <= '0;
            r_valid         <= '0;
            r_j             <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BIN_COUNT:     r_bin_count     <= i_cfg_data[BINS_W-1:0];
                    CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                    default:           r_bin_count     <= r_bin_count;
                endcase
            end
            if (i_cmd.load && (r_fill != CNT_MAX)) begin
                r_fill <= r_fill + WIN_W'(1);
            end
            if (do_write) begin
                r_valid[r_bin[ADDR_W-1:0]] <= 1'b1;
            end
            if (i_cmd.emit_ld) begin
                r_out_valid <= 1'b1;
                if (emit_last) begin
                    r_j     <= '0;
                    r_fill  <= '0;
                    r_valid <= '0;
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_eos    <= i_eos;
        end
        if (i_cmd.map) begin
            r_hit <= hit;
            r_bin <= prod_m1[22:17];
        end
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[r_bin[ADDR_W-1:0]];
        end
        if (i_cmd.emit_rd) begin
            r_rd_valid <= r_valid[r_j[ADDR_W-1:0]];
        end
        if (i_cmd.emit_ld) begin
            r_out_idx   <= r_j;
            r_out_total <= cur_cnt;
            r_out_last  <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_out_total, r_out_idx};
    assign o_out_last  = r_out_last;

endmodule

>>> src/windowed_sample_histogram_top.sv
// Windowed amplitude histogram. Each sample on the slave stream is counted in one of
// bin_count equal bins spanning minus one to plus one (samples at or below -1 or above
// +1 count nowhere but still fill the window). After window_length samples, or after a
// sample marked with tlast, the counts of bins 0 to m-1 leave on the master stream in
// bin order, the final bin with tlast, and all counts restart from zero. A sample passes
// through acceptance, the bin multiply, then read and write of the counter in the
// counter RAM. An emission reads each bin from the RAM, then loads the output
// register, waiting while the master side holds tready low. An invalid
// configuration falls back to the default bin count and window length.
module windowed_sample_histogram_top #(
    parameter int MAX_BINS   = 64,
    parameter int MAX_WINDOW = 30000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sample[17:0], zero pad
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // bin_index[5:0], bin_total[20:6], zero pad
    output logic        m_axis_tlast,   // last_bin
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    import whs_pkg::*;

    t_cmd    cmd;
    t_status status;

    whs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    whs_dpath #(
        .MAX_BINS   (MAX_BINS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_eos       (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    assign o_cfg_ready = 1'b1;

endmodule

>>> src/whs_check.sv
module whs_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [5:0] r_exp_idx;
    logic       r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
            r_mid     <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_exp_idx <= m_axis_tlast ? 6'd0 : (m_axis_tdata[5:0] + 6'd1);
            r_mid     <= !m_axis_tlast;
        end
    end

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // bins leave in order, restarting at zero after the last
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] == r_exp_idx))
        else $error("bin index out of order");

    // no sample taken in the middle of a window readout
    a_no_input_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid && !(m_axis_tvalid && m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted during readout");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind windowed_sample_histogram_top whs_check u_whs_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/whs_histogram_checker.sv
module whs_histogram_checker #(
    parameter int MAX_BINS   = 64,
    parameter int MAX_WINDOW = 30000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_samples,
    output int          o_windows,
    output int          o_bin_totals
);
    timeunit 1ns;
    timeprecision 1ps;

    import whs_pkg::*;

    localparam int HALF_SPAN    = 65536;
    localparam int FULL_SPAN    = 131072;
    localparam int FALLBACK_BINS = 100;
    localparam int FALLBACK_WIN  = 1024;
    localparam logic [14:0] COUNT_TOP = 15'h7FFF;

    typedef struct packed {
        logic [5:0]  idx;
        logic [14:0] total;
        logic        last;
    } t_bin_result;

    logic [6:0]  bins_reg;
    logic [14:0] window_reg;
    logic [14:0] bin_counts [MAX_BINS];
    logic [14:0] window_fill;
    t_bin_result bin_results_due [$];

    assign o_pending = bin_results_due.size();

    // one sample into the histogram, queuing the bin totals of a finished window
    task automatic count_sample(input logic signed [17:0] smp, input logic eos);
        int m;
        int n;
        int u;
        int bin;
        t_bin_result res;
        if (window_reg == 0 || window_reg > MAX_WINDOW || bins_reg == 0) begin
            m = (FALLBACK_BINS > MAX_BINS) ? MAX_BINS : FALLBACK_BINS;
            n = (FALLBACK_WIN > MAX_WINDOW) ? MAX_WINDOW : FALLBACK_WIN;
        end else begin
            m = (bins_reg > MAX_BINS) ? MAX_BINS : int'(bins_reg);
            n = int'(window_reg);
        end
        u = int'(smp) + HALF_SPAN;
        if (u > 0 && u <= FULL_SPAN) begin
            bin = (u * m - 1) / FULL_SPAN;
            if (bin < m && bin < MAX_BINS && bin_counts[bin] != COUNT_TOP)
                bin_counts[bin] = bin_counts[bin] + 15'd1;
        end
        if (window_fill != COUNT_TOP)
            window_fill = window_fill + 15'd1;
        if (int'(window_fill) >= n || eos) begin
            for (int j = 0; j < m; j++) begin
                res.idx   = 6'(j);
                res.total = bin_counts[j];
                res.last  = (j == m - 1);
                bin_results_due.push_back(res);
            end
            foreach (bin_counts[k])
                bin_counts[k] = '0;
            window_fill = '0;
            o_windows++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_result want;
        if (!i_rst_n) begin
            bins_reg = 7'd64;
            window_reg = 15'd1024;
            foreach (bin_counts[k])
                bin_counts[k] = '0;
            window_fill = '0;
            bin_results_due.delete();
            o_mismatches = 0;
            o_samples = 0;
            o_windows = 0;
            o_bin_totals = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BIN_COUNT)
                    bins_reg = i_cfg_data[6:0];
                else
                    window_reg = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                count_sample($signed(s_axis_tdata[17:0]), s_axis_tlast);
                o_samples++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                o_bin_totals++;
                if (bin_results_due.size() == 0) begin
                    $error("unexpected bin transaction: bin_index %0d bin_total %0d",
                           m_axis_tdata[5:0], m_axis_tdata[20:6]);
                    o_mismatches++;
                end else begin
                    want = bin_results_due.pop_front();
                    if (m_axis_tdata[5:0] !== want.idx) begin
                        $error("bin_index: expected %0d, actual %0d",
                               want.idx, m_axis_tdata[5:0]);
                        o_mismatches++;
                    end
                    if (m_axis_tdata[20:6] !== want.total) begin
                        $error("bin_total: expected %0d, actual %0d",
                               want.total, m_axis_tdata[20:6]);
                        o_mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_bin: expected %0d, actual %0d",
                               want.last, m_axis_tlast);
                        o_mismatches++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_windowed_sample_histogram_top.sv
module tb_windowed_sample_histogram_top;
    timeunit 1ns;
    timeprecision 1ps;
    import whs_pkg::*;

    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [14:0] i_cfg_data;

    int mismatches;
    int outstanding;
    int samples_seen;
    int windows_seen;
    int totals_seen;
    int quiet_cycles = 0;
    int settings_used = 0;
    int edge_m = 64;
    bit stall_on = 1'b0;

    int edge_samples[$] = '{-131072, -65537, -65536, -65535, -63488, -63487, -1, 0, 1,
                            2047, 2048, 2049, 63488, 65535, 65536, 65537, 131071, 131071};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    windowed_sample_histogram_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    whs_histogram_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (outstanding),
        .o_samples     (samples_seen),
        .o_windows     (windows_seen),
        .o_bin_totals  (totals_seen)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_windowed_sample_histogram_top: done, errors");
                $finish;
            end
        end
    end

    // bin total receiver with random back-pressure
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = stall_on ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    task automatic send_sample(input logic signed [17:0] smp, input logic eos);
        int gap;
        gap = stall_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {6'd0, smp};
        s_axis_tlast  <= eos;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [14:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // hold off samples until every bin total is back and the pipeline is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(input int m_sel, input int n_sel);
        logic [14:0] bins_word;
        bins_word = {8'($urandom_range(0, 255)), 7'(m_sel)};
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_BIN_COUNT, bins_word);
            write_reg(CFG_WINDOW_LENGTH, 15'(n_sel));
        end else begin
            write_reg(CFG_WINDOW_LENGTH, 15'(n_sel));
            write_reg(CFG_BIN_COUNT, bins_word);
        end
        settings_used++;
        if (m_sel == 0 || n_sel == 0 || n_sel > 30000)
            edge_m = 64;
        else
            edge_m = (m_sel > 64) ? 64 : m_sel;
    endtask

    function automatic logic signed [17:0] pick_sample();
        int u;
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 18'(int'($urandom_range(0, 131071)) - 65535);
            6: return 18'($urandom);
            7: begin
                unique case ($urandom_range(0, 3))
                    0: return -18'sd65536;
                    1: return -18'sd65535;
                    2: return 18'sd65536;
                    default: return 18'sd65537;
                endcase
            end
            8: begin
                u = (131072 * int'($urandom_range(0, edge_m))) / edge_m
                    + int'($urandom_range(0, 2)) - 1;
                return 18'(u - 65536);
            end
            default: return 18'(int'($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    initial begin
        int phase;
        int pick;
        int len;
        int sent;
        int m_sel;
        int n_sel;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_BIN_COUNT;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: bin edges and range limits, closed by end of stream
        foreach (edge_samples[i])
            send_sample(18'(edge_samples[i]), i == edge_samples.size() - 1);
        drain();

        // single bin, single-sample windows, end of stream on a full window
        apply_settings(1, 1);
        send_sample(18'sd65536, 1'b0);
        send_sample(-18'sd65536, 1'b0);
        send_sample(18'sd131071, 1'b1);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            stall_on = ($urandom_range(0, 3) != 0);
            pick = (phase < 6) ? phase : $urandom_range(0, 9);
            unique case (pick)
                0: begin
                    m_sel = 64;
                    n_sel = 30000;
                end
                1: begin
                    m_sel = 1;
                    n_sel = 1;
                end
                2: begin
                    m_sel = 0;
                    n_sel = $urandom_range(1, 48);
                end
                3: begin
                    m_sel = $urandom_range(65, 127);
                    n_sel = $urandom_range(1, 48);
                end
                4: begin
                    m_sel = $urandom_range(1, 64);
                    n_sel = 0;
                end
                5: begin
                    m_sel = $urandom_range(1, 64);
                    n_sel = $urandom_range(30001, 32767);
                end
                default: begin
                    m_sel = $urandom_range(1, 64);
                    n_sel = $urandom_range(1, 48);
                end
            endcase
            apply_settings(m_sel, n_sel);
            len = $urandom_range(10, 40);
            repeat (len) begin
                send_sample(pick_sample(), $urandom_range(0, 19) == 0);
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            sent += len;
            phase++;
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("run covered %0d samples under %0d register settings plus reset values",
                 samples_seen, settings_used);
        $display("%0d windows emitted, %0d bin totals compared", windows_seen, totals_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_windowed_sample_histogram_top: done, clean");
        else
            $display("tb_windowed_sample_histogram_top: done, errors");
        $finish;
    end

endmodule
